@@ design/detector_row_decode_core_macros.svh @@
// ----------------------------------------------------------------------------
// Detector row decode assertion macros
// Concurrent assertion forms for the detector row decode core.
// ----------------------------------------------------------------------------
`ifndef DETECTOR_ROW_DECODE_CORE_MACROS_SVH
`define DETECTOR_ROW_DECODE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DRD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/drd_pkg.sv @@
// ----------------------------------------------------------------------------
// Detector row decode package
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package drd_pkg;

    // Field widths.
    localparam int VALUE_W     = 32;
    localparam int THRESH_W    = 17;
    localparam int COUNT_W     = 8;
    localparam int SCALE_W     = 24;
    localparam int FRAME_W     = 12;
    localparam int EDGE_W      = 16;
    localparam int EXTENT_W    = 21;
    localparam int CLASS_OUT_W = 7;
    localparam int CLASS_OUT_MAX = (1 << CLASS_OUT_W) - 1;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index REG_SCORE_THRESHOLD = 3'd0;
    localparam t_cfg_index REG_ANCHOR_FREE     = 3'd1;
    localparam t_cfg_index REG_CLASS_COUNT     = 3'd2;
    localparam t_cfg_index REG_HSCALE          = 3'd3;
    localparam t_cfg_index REG_VSCALE          = 3'd4;
    localparam t_cfg_index REG_FRAME_COLUMNS   = 3'd5;
    localparam t_cfg_index REG_FRAME_ROWS      = 3'd6;

    // Register reset values.
    localparam logic [THRESH_W-1:0] RST_SCORE_THRESHOLD = 17'd29491;
    localparam logic                RST_ANCHOR_FREE     = 1'b0;
    localparam logic [COUNT_W-1:0]  RST_CLASS_COUNT     = 8'd80;
    localparam logic [SCALE_W-1:0]  RST_HSCALE          = 24'd100825;
    localparam logic [SCALE_W-1:0]  RST_VSCALE          = 24'd75618;
    localparam logic [FRAME_W-1:0]  RST_FRAME_COLUMNS   = 12'd640;
    localparam logic [FRAME_W-1:0]  RST_FRAME_ROWS      = 12'd480;

    // Row layout: four box values, then objectness (single-stage only), then scores.
    localparam int MAX_CLASSES_DEF   = 128;
    localparam int FIELD_CENTER_X    = 0;
    localparam int FIELD_CENTER_Y    = 1;
    localparam int FIELD_WIDTH       = 2;
    localparam int FIELD_HEIGHT      = 3;
    localparam int BOX_VALUES        = 4;
    localparam int SINGLE_STAGE_BASE = 5;

    // Fixed-point arithmetic.
    localparam int SCORE_FRAC   = 16;
    localparam int SCORE_PROD_W = 2 * VALUE_W;
    // (2*c - size) is 34 bits signed; the scale is made signed by one zero bit.
    localparam int EDGE_PROD_W  = VALUE_W + 2 + SCALE_W + 1;
    localparam int SIZE_PROD_W  = VALUE_W + SCALE_W + 1;
    localparam int EDGE_SHIFT   = 33;
    localparam int SIZE_SHIFT   = 32;
    localparam int EXTENT_MIN   = -1048576;
    localparam int EXTENT_MAX   = 4095;

    // Clipped box along one axis.
    typedef struct packed {
        logic [EDGE_W-1:0]          start_px;
        logic signed [EXTENT_W-1:0] extent;
    } t_axis_box;

endpackage

@@ design/drd_axis_clip.sv @@
// ----------------------------------------------------------------------------
// Detector row decode axis clip
// Turns the scaled edge and size products of one axis into the clipped start
// edge and the extent limited to the frame remainder, both saturated.
// ----------------------------------------------------------------------------
module drd_axis_clip (
    input  logic signed [drd_pkg::EDGE_PROD_W-1:0] i_edge_prod,
    input  logic signed [drd_pkg::SIZE_PROD_W-1:0] i_size_prod,
    input  logic [drd_pkg::FRAME_W-1:0]            i_frame,
    output drd_pkg::t_axis_box                     o_box
);

    localparam int START_W = drd_pkg::EDGE_PROD_W - 1 - drd_pkg::EDGE_SHIFT;
    localparam int SPAN_W  = drd_pkg::SIZE_PROD_W - drd_pkg::SIZE_SHIFT;
    localparam int DIFF_W  = START_W + 2;
    localparam int BIAS_W  = drd_pkg::SIZE_PROD_W + 1;

    logic [START_W-1:0]      start_full;
    logic signed [BIAS_W-1:0] size_bias;
    logic signed [SPAN_W:0]  span;
    logic signed [DIFF_W-1:0] span_ext;
    logic signed [DIFF_W-1:0] room;
    logic signed [DIFF_W-1:0] pick;

    // A non-positive edge product clips to zero; otherwise drop the fraction bits.
    always_comb begin
        if (i_edge_prod > 0) begin
            start_full = i_edge_prod[drd_pkg::EDGE_PROD_W-2:drd_pkg::EDGE_SHIFT];
        end else begin
            start_full = '0;
        end
    end

    // Start edge saturates to the output range.
    always_comb begin
        if (|start_full[START_W-1:drd_pkg::EDGE_W]) begin
            o_box.start_px = '1;
        end else begin
            o_box.start_px = start_full[drd_pkg::EDGE_W-1:0];
        end
    end

    // Scaled size truncated toward zero: bias negative products before the shift.
    always_comb begin
        size_bias = BIAS_W'(i_size_prod);
        if (i_size_prod[drd_pkg::SIZE_PROD_W-1]) begin
            size_bias = size_bias + BIAS_W'((64'd1 << drd_pkg::SIZE_SHIFT) - 64'd1);
        end
        span = size_bias[BIAS_W-1:drd_pkg::SIZE_SHIFT];
    end

    // Limit to the frame remainder past the start edge, then saturate.
    always_comb begin
        span_ext = DIFF_W'(span);
        room     = $signed({{(DIFF_W - drd_pkg::FRAME_W){1'b0}}, i_frame})
                 - $signed({2'b00, start_full});
        pick     = (span_ext < room) ? span_ext : room;
        if (pick < DIFF_W'(drd_pkg::EXTENT_MIN)) begin
            o_box.extent = drd_pkg::EXTENT_W'(drd_pkg::EXTENT_MIN);
        end else if (pick > DIFF_W'(drd_pkg::EXTENT_MAX)) begin
            o_box.extent = drd_pkg::EXTENT_W'(drd_pkg::EXTENT_MAX);
        end else begin
            o_box.extent = pick[drd_pkg::EXTENT_W-1:0];
        end
    end

endmodule

@@ design/detector_row_decode_core.sv @@
// ----------------------------------------------------------------------------
// Detector row decode core
// Accepts one row value per cycle while the input is ready; the result of a
// row passes the score, product and output registers after the last value of
// the row is accepted. Output stalls hold the pipeline and then the input.
// Synchronous active-low reset loads register defaults and starts a new row.
// ----------------------------------------------------------------------------
`include "detector_row_decode_core_macros.svh"

module detector_row_decode_core #(
    parameter int MAX_CLASSES = drd_pkg::MAX_CLASSES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [drd_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [drd_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // Row value input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [drd_pkg::VALUE_W-1:0]     i_row_value,
    // Detection output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [drd_pkg::EDGE_W-1:0]             o_box_left,
    output logic [drd_pkg::EDGE_W-1:0]             o_box_top,
    output logic signed [drd_pkg::EXTENT_W-1:0]    o_box_width,
    output logic signed [drd_pkg::EXTENT_W-1:0]    o_box_height,
    output logic [drd_pkg::CLASS_OUT_W-1:0]        o_class_index,
    output logic signed [drd_pkg::VALUE_W-1:0]     o_confidence
);

    localparam int POS_W = $clog2(MAX_CLASSES + drd_pkg::SINGLE_STAGE_BASE);
    localparam int CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int VW    = drd_pkg::VALUE_W;

    // Configuration registers
    logic [drd_pkg::THRESH_W-1:0] r_thr;
    logic                         r_anchor_free;
    logic [drd_pkg::COUNT_W-1:0]  r_class_count;
    logic [drd_pkg::SCALE_W-1:0]  r_hscale;
    logic [drd_pkg::SCALE_W-1:0]  r_vscale;
    logic [drd_pkg::FRAME_W-1:0]  r_frame_cols;
    logic [drd_pkg::FRAME_W-1:0]  r_frame_rows;

    // Row state
    logic [POS_W-1:0]        r_pos;
    logic signed [VW-1:0]    r_center_x;
    logic signed [VW-1:0]    r_center_y;
    logic signed [VW-1:0]    r_box_w;
    logic signed [VW-1:0]    r_box_h;
    logic signed [VW-1:0]    r_objectness;
    logic signed [VW-1:0]    r_best;
    logic [CLS_W-1:0]        r_best_cls;
    logic                    r_rejected;

    // Score stage
    logic                                        r_s1_valid;
    logic signed [VW-1:0]                        r_s1_value;
    logic signed [drd_pkg::SCORE_PROD_W-1:0]     r_s1_prod;
    logic                                        r_s1_score;
    logic [CLS_W-1:0]                            r_s1_cls;
    logic                                        r_s1_last;
    logic                                        r_s1_rej;

    // Product stage
    logic                                        r_s2_valid;
    logic signed [drd_pkg::EDGE_PROD_W-1:0]      r_s2_edge_x;
    logic signed [drd_pkg::EDGE_PROD_W-1:0]      r_s2_edge_y;
    logic signed [drd_pkg::SIZE_PROD_W-1:0]      r_s2_size_x;
    logic signed [drd_pkg::SIZE_PROD_W-1:0]      r_s2_size_y;
    logic [CLS_W-1:0]                            r_s2_cls;
    logic signed [VW-1:0]                        r_s2_conf;

    // Output register
    logic                                        r_out_valid;

    // Decode and flow control
    logic [POS_W-1:0]        count_eff;
    logic [POS_W-1:0]        base_pos;
    logic [POS_W-1:0]        last_pos;
    logic [POS_W-1:0]        class_off;
    logic                    in_last;
    logic                    in_obj;
    logic                    in_score;
    logic                    in_acc;
    logic                    out_free;
    logic                    s2_free;
    logic                    s1_go;
    logic signed [VW-1:0]    thr_ext;

    // Score stage logic
    logic signed [drd_pkg::SCORE_PROD_W-1:0] score_sh;
    logic signed [VW-1:0]    score_sat;
    logic signed [VW-1:0]    score_now;
    logic signed [VW-1:0]    best_now;
    logic [CLS_W-1:0]        cls_now;
    logic                    rej_now;
    logic                    s1_emit;
    logic signed [VW+1:0]    span_x;
    logic signed [VW+1:0]    span_y;

    // Clip results
    drd_pkg::t_axis_box      box_x;
    drd_pkg::t_axis_box      box_y;

    assign thr_ext = $signed({{(VW - drd_pkg::THRESH_W){1'b0}}, r_thr});

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr         <= drd_pkg::RST_SCORE_THRESHOLD;
            r_anchor_free <= drd_pkg::RST_ANCHOR_FREE;
            r_class_count <= drd_pkg::RST_CLASS_COUNT;
            r_hscale      <= drd_pkg::RST_HSCALE;
            r_vscale      <= drd_pkg::RST_VSCALE;
            r_frame_cols  <= drd_pkg::RST_FRAME_COLUMNS;
            r_frame_rows  <= drd_pkg::RST_FRAME_ROWS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                drd_pkg::REG_SCORE_THRESHOLD: r_thr <= i_cfg_data[drd_pkg::THRESH_W-1:0];
                drd_pkg::REG_ANCHOR_FREE:     r_anchor_free <= i_cfg_data[0];
                drd_pkg::REG_CLASS_COUNT:     r_class_count <= i_cfg_data[drd_pkg::COUNT_W-1:0];
                drd_pkg::REG_HSCALE:          r_hscale <= i_cfg_data[drd_pkg::SCALE_W-1:0];
                drd_pkg::REG_VSCALE:          r_vscale <= i_cfg_data[drd_pkg::SCALE_W-1:0];
                drd_pkg::REG_FRAME_COLUMNS:   r_frame_cols <= i_cfg_data[drd_pkg::FRAME_W-1:0];
                drd_pkg::REG_FRAME_ROWS:      r_frame_rows <= i_cfg_data[drd_pkg::FRAME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Row layout decode from the current position and configuration.
    always_comb begin
        if (r_class_count == '0) begin
            count_eff = POS_W'(1);
        end else if (32'(r_class_count) > MAX_CLASSES) begin
            count_eff = POS_W'(MAX_CLASSES);
        end else begin
            count_eff = POS_W'(r_class_count);
        end
        base_pos  = r_anchor_free ? POS_W'(drd_pkg::BOX_VALUES)
                                  : POS_W'(drd_pkg::SINGLE_STAGE_BASE);
        last_pos  = base_pos + count_eff - POS_W'(1);
        class_off = r_pos - base_pos;
        in_last   = (r_pos >= last_pos);
        in_obj    = !r_anchor_free && (r_pos == POS_W'(drd_pkg::BOX_VALUES));
        in_score  = !in_obj && (r_pos >= base_pos) && (class_off < count_eff);
    end

    // Bubbles collapse: a stage moves when the one after it is empty or moving.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_free    = !r_s2_valid || out_free;
    assign o_in_ready = !r_s1_valid || s2_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign s1_go      = r_s1_valid && s2_free;

    // Position counter and box value capture at each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_box_w      <= '0;
            r_box_h      <= '0;
            r_objectness <= '0;
        end else if (in_acc) begin
            r_pos <= in_last ? '0 : r_pos + POS_W'(1);
            if (r_pos == POS_W'(drd_pkg::FIELD_CENTER_X)) begin
                r_center_x <= i_row_value;
            end
            if (r_pos == POS_W'(drd_pkg::FIELD_CENTER_Y)) begin
                r_center_y <= i_row_value;
            end
            if (r_pos == POS_W'(drd_pkg::FIELD_WIDTH)) begin
                r_box_w <= i_row_value;
            end
            if (r_pos == POS_W'(drd_pkg::FIELD_HEIGHT)) begin
                r_box_h <= i_row_value;
            end
            if (in_obj) begin
                r_objectness <= i_row_value;
            end
        end
    end

    // Score stage register: beat flags and the raw score times objectness.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_value <= i_row_value;
            r_s1_prod  <= drd_pkg::SCORE_PROD_W'(i_row_value)
                        * drd_pkg::SCORE_PROD_W'(r_objectness);
            r_s1_score <= in_score;
            r_s1_cls   <= CLS_W'(class_off);
            r_s1_last  <= in_last;
            r_s1_rej   <= in_obj && (i_row_value < thr_ext);
        end
    end

    // Score rounds toward minus infinity and saturates to 32 bits.
    always_comb begin
        score_sh = r_s1_prod >>> drd_pkg::SCORE_FRAC;
        if ((&score_sh[drd_pkg::SCORE_PROD_W-1:VW-1])
            || !(|score_sh[drd_pkg::SCORE_PROD_W-1:VW-1])) begin
            score_sat = score_sh[VW-1:0];
        end else if (score_sh[drd_pkg::SCORE_PROD_W-1]) begin
            score_sat = {1'b1, {(VW-1){1'b0}}};
        end else begin
            score_sat = {1'b0, {(VW-1){1'b1}}};
        end
        score_now = r_anchor_free ? r_s1_value : score_sat;
    end

    // Running best: strictly greater wins, so ties keep the first class.
    always_comb begin
        if (r_s1_score && (score_now > r_best)) begin
            best_now = score_now;
            cls_now  = r_s1_cls;
        end else begin
            best_now = r_best;
            cls_now  = r_best_cls;
        end
        rej_now = r_rejected || r_s1_rej;
        s1_emit = r_s1_last && !rej_now && (best_now >= thr_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best     <= '0;
            r_best_cls <= '0;
            r_rejected <= 1'b0;
        end else if (s1_go) begin
            if (r_s1_last) begin
                r_best     <= '0;
                r_best_cls <= '0;
                r_rejected <= 1'b0;
            end else begin
                r_best     <= best_now;
                r_best_cls <= cls_now;
                r_rejected <= rej_now;
            end
        end
    end

    // Edge numerators: center minus half size, kept exact as 2*c - size.
    always_comb begin
        span_x = $signed({r_center_x[VW-1], r_center_x, 1'b0}) - (VW+2)'(r_box_w);
        span_y = $signed({r_center_y[VW-1], r_center_y, 1'b0}) - (VW+2)'(r_box_h);
    end

    // Product stage: scale the box values for an emitted row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= s1_go && s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_emit) begin
            r_s2_edge_x <= drd_pkg::EDGE_PROD_W'(span_x)
                         * drd_pkg::EDGE_PROD_W'($signed({1'b0, r_hscale}));
            r_s2_edge_y <= drd_pkg::EDGE_PROD_W'(span_y)
                         * drd_pkg::EDGE_PROD_W'($signed({1'b0, r_vscale}));
            r_s2_size_x <= drd_pkg::SIZE_PROD_W'(r_box_w)
                         * drd_pkg::SIZE_PROD_W'($signed({1'b0, r_hscale}));
            r_s2_size_y <= drd_pkg::SIZE_PROD_W'(r_box_h)
                         * drd_pkg::SIZE_PROD_W'($signed({1'b0, r_vscale}));
            r_s2_cls    <= cls_now;
            r_s2_conf   <= best_now;
        end
    end

    // Clip stage: one clip unit per axis.
    drd_axis_clip u_clip_x (
        .i_edge_prod (r_s2_edge_x),
        .i_size_prod (r_s2_size_x),
        .i_frame     (r_frame_cols),
        .o_box       (box_x)
    );

    drd_axis_clip u_clip_y (
        .i_edge_prod (r_s2_edge_y),
        .i_size_prod (r_s2_size_y),
        .i_frame     (r_frame_rows),
        .o_box       (box_y)
    );

    // Output register holds a beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && out_free) begin
            o_box_left   <= box_x.start_px;
            o_box_top    <= box_y.start_px;
            o_box_width  <= box_x.extent;
            o_box_height <= box_y.extent;
            o_confidence <= r_s2_conf;
            if (32'(r_s2_cls) > drd_pkg::CLASS_OUT_MAX) begin
                o_class_index <= drd_pkg::CLASS_OUT_W'(drd_pkg::CLASS_OUT_MAX);
            end else begin
                o_class_index <= drd_pkg::CLASS_OUT_W'(r_s2_cls);
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // Checks on row sequencing and rate.
    `DRD_ASSERT_NEXT(a_row_end_wraps, i_clk, i_rst_n, in_acc && in_last, r_pos == '0, "position did not wrap at row end")
    `DRD_ASSERT_NEXT(a_pos_steps, i_clk, i_rst_n, in_acc && !in_last, r_pos == POS_W'($past(r_pos) + POS_W'(1)), "position did not advance")
    `DRD_ASSERT_SAME(a_row_start_clear, i_clk, i_rst_n, (r_pos == '0) && !r_s1_valid, (r_best == '0) && !r_rejected, "row state not cleared at row start")
    `DRD_ASSERT_SAME(a_ready_when_out_free, i_clk, i_rst_n, !r_out_valid, o_in_ready, "input stalled with an empty output register")

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Detector row decode core testbench
// Streams detector rows into the core one value per beat and predicts every
// detection from an internal model of the row decoder. Detections are checked
// field by field, in order, against the predicted ones. Both channels idle and
// stall at random, and the configuration is changed between phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register index with no register behind it.
    localparam drd_pkg::t_cfg_index REG_SPARE = 3'd7;

    localparam longint CONF_MIN = -64'sd2147483648;
    localparam longint CONF_MAX = 64'sd2147483647;
    localparam int DRAIN_CYCLES = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 380;

    typedef struct packed {
        logic [drd_pkg::EDGE_W-1:0]          left;
        logic [drd_pkg::EDGE_W-1:0]          top;
        logic signed [drd_pkg::EXTENT_W-1:0] width;
        logic signed [drd_pkg::EXTENT_W-1:0] height;
        logic [drd_pkg::CLASS_OUT_W-1:0]     cls;
        logic signed [drd_pkg::VALUE_W-1:0]  conf;
    } t_detection;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [drd_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [drd_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    logic signed [drd_pkg::VALUE_W-1:0] i_row_value;
    logic o_out_valid;
    logic i_out_ready;
    logic [drd_pkg::EDGE_W-1:0] o_box_left;
    logic [drd_pkg::EDGE_W-1:0] o_box_top;
    logic signed [drd_pkg::EXTENT_W-1:0] o_box_width;
    logic signed [drd_pkg::EXTENT_W-1:0] o_box_height;
    logic [drd_pkg::CLASS_OUT_W-1:0] o_class_index;
    logic signed [drd_pkg::VALUE_W-1:0] o_confidence;

    detector_row_decode_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_row_value  (i_row_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_width  (o_box_width),
        .o_box_height (o_box_height),
        .o_class_index(o_class_index),
        .o_confidence (o_confidence)
    );

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register copy kept by the predictor.
    logic [drd_pkg::THRESH_W-1:0] cfg_threshold;
    logic                         cfg_anchor_free;
    logic [drd_pkg::COUNT_W-1:0]  cfg_class_count;
    logic [drd_pkg::SCALE_W-1:0]  cfg_hscale;
    logic [drd_pkg::SCALE_W-1:0]  cfg_vscale;
    logic [drd_pkg::FRAME_W-1:0]  cfg_frame_columns;
    logic [drd_pkg::FRAME_W-1:0]  cfg_frame_rows;

    // Row state kept by the predictor.
    int     row_pos;
    longint center_x;
    longint center_y;
    longint raw_width;
    longint raw_height;
    longint objectness;
    longint best_score;
    int     best_class;
    bit     row_rejected;

    t_detection pending_detections[$];
    int  mismatch_count;
    int  random_items;
    int  big_rows;
    bit  no_gaps;
    bit  no_backpressure;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Box edge: (2*c - size) has 17 fraction bits, times a Q8.16 scale.
    function automatic longint edge_px(longint c, longint size, longint scale);
        longint p;
        p = (2 * c - size) * scale;
        return (p <= 0) ? 0 : (p >> drd_pkg::EDGE_SHIFT);
    endfunction

    // Box extent: truncated toward zero, then clipped to the frame remainder.
    function automatic longint extent_px(longint size, longint scale, longint frame,
                                         longint start_edge);
        longint t;
        longint r;
        t = size * scale;
        t = (t < 0) ? -((-t) >> drd_pkg::SIZE_SHIFT) : (t >> drd_pkg::SIZE_SHIFT);
        r = frame - start_edge;
        return clamp((t < r) ? t : r, drd_pkg::EXTENT_MIN, drd_pkg::EXTENT_MAX);
    endfunction

    // Advances the row state by one value; returns 1 when a detection is due.
    function automatic bit decode_row_value(input logic signed [drd_pkg::VALUE_W-1:0] value,
                                            output t_detection det);
        longint v;
        longint thr;
        longint p;
        longint s;
        longint left;
        longint top;
        int count;
        int base;
        int last;
        int pos;
        bit emitted;
        v = longint'(value);
        thr = longint'(cfg_threshold);
        count = int'(cfg_class_count);
        pos = row_pos;
        emitted = 1'b0;
        det = '0;
        if (count == 0)
            count = 1;
        if (count > drd_pkg::MAX_CLASSES_DEF)
            count = drd_pkg::MAX_CLASSES_DEF;
        base = cfg_anchor_free ? drd_pkg::BOX_VALUES : drd_pkg::SINGLE_STAGE_BASE;
        last = base + count - 1;

        if (pos == drd_pkg::FIELD_CENTER_X) begin
            center_x = v;
        end else if (pos == drd_pkg::FIELD_CENTER_Y) begin
            center_y = v;
        end else if (pos == drd_pkg::FIELD_WIDTH) begin
            raw_width = v;
        end else if (pos == drd_pkg::FIELD_HEIGHT) begin
            raw_height = v;
        end else if (!cfg_anchor_free && pos == drd_pkg::BOX_VALUES) begin
            objectness = v;
            if (v < thr)
                row_rejected = 1'b1;
        end else if (pos >= base && pos - base < count) begin
            // Single-stage scores are weighted by objectness, floored.
            if (cfg_anchor_free) begin
                s = v;
            end else begin
                p = v * objectness;
                s = (p < 0) ? -(((-p) + 65535) >> drd_pkg::SCORE_FRAC)
                            : (p >> drd_pkg::SCORE_FRAC);
                s = clamp(s, CONF_MIN, CONF_MAX);
            end
            if (s > best_score) begin
                best_score = s;
                best_class = pos - base;
            end
        end

        if (pos >= last) begin
            if (!row_rejected && best_score >= thr) begin
                left = edge_px(center_x, raw_width, longint'(cfg_hscale));
                top = edge_px(center_y, raw_height, longint'(cfg_vscale));
                det.left = drd_pkg::EDGE_W'(clamp(left, 0, 65535));
                det.top = drd_pkg::EDGE_W'(clamp(top, 0, 65535));
                det.width = drd_pkg::EXTENT_W'(extent_px(raw_width, longint'(cfg_hscale),
                                                         longint'(cfg_frame_columns), left));
                det.height = drd_pkg::EXTENT_W'(extent_px(raw_height, longint'(cfg_vscale),
                                                          longint'(cfg_frame_rows), top));
                det.cls = drd_pkg::CLASS_OUT_W'((best_class > drd_pkg::CLASS_OUT_MAX) ?
                                                drd_pkg::CLASS_OUT_MAX : best_class);
                det.conf = best_score[drd_pkg::VALUE_W-1:0];
                emitted = 1'b1;
            end
            row_pos = 0;
            best_score = 0;
            best_class = 0;
            row_rejected = 1'b0;
        end else begin
            row_pos = pos + 1;
        end
        return emitted;
    endfunction

    // Draws the next value, shaped by the field that the row expects next.
    function automatic logic signed [drd_pkg::VALUE_W-1:0] draw_row_value();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        if (row_pos == drd_pkg::FIELD_CENTER_X || row_pos == drd_pkg::FIELD_CENTER_Y)
            return $signed($urandom_range(0, 900 << 16)) - (50 << 16);
        if (row_pos == drd_pkg::FIELD_WIDTH || row_pos == drd_pkg::FIELD_HEIGHT)
            return $urandom_range(0, 500 << 16);
        if (!cfg_anchor_free && row_pos == drd_pkg::BOX_VALUES)
            return $urandom_range(32'h6000, 32'h10000);
        return $urandom_range(0, 32'h10000);
    endfunction

    // Sends one row value beat and records the detection it causes, if any.
    task automatic send_row_value(input logic signed [drd_pkg::VALUE_W-1:0] value);
        int gap;
        t_detection det;
        gap = no_gaps ? 0 : int'($urandom_range(0, 11));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_row_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        if (decode_row_value(value, det))
            pending_detections = {pending_detections, det};
    endtask

    // Stops the input and waits until every predicted detection has left or the drain limit runs out.
    task automatic drain_detections();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_detections.size() != 0 && waited < DRAIN_CYCLES) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register beat; the predictor takes the value at the same edge.
    task automatic write_register(input drd_pkg::t_cfg_index idx,
                                  input logic [drd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            drd_pkg::REG_SCORE_THRESHOLD: cfg_threshold = data[drd_pkg::THRESH_W-1:0];
            drd_pkg::REG_ANCHOR_FREE:     cfg_anchor_free = data[0];
            drd_pkg::REG_CLASS_COUNT:     cfg_class_count = data[drd_pkg::COUNT_W-1:0];
            drd_pkg::REG_HSCALE:          cfg_hscale = data[drd_pkg::SCALE_W-1:0];
            drd_pkg::REG_VSCALE:          cfg_vscale = data[drd_pkg::SCALE_W-1:0];
            drd_pkg::REG_FRAME_COLUMNS:   cfg_frame_columns = data[drd_pkg::FRAME_W-1:0];
            drd_pkg::REG_FRAME_ROWS:      cfg_frame_rows = data[drd_pkg::FRAME_W-1:0];
            default: ;
        endcase
        // Valid goes low between writes.
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One full row at the reset register values.
    task automatic test_default_config();
        repeat (drd_pkg::SINGLE_STAGE_BASE + int'(drd_pkg::RST_CLASS_COUNT))
            send_row_value(draw_row_value());
        drain_detections();
    endtask

    // Field extremes, a row with no positive score, a zero class count and a
    // zero-sized frame.
    task automatic test_extremes();
        write_register(drd_pkg::REG_SCORE_THRESHOLD, 24'd0);
        write_register(drd_pkg::REG_ANCHOR_FREE, 24'd1);
        write_register(drd_pkg::REG_CLASS_COUNT, 24'd0);
        write_register(drd_pkg::REG_HSCALE, 24'hFFFFFF);
        write_register(drd_pkg::REG_VSCALE, 24'hFFFFFF);
        write_register(drd_pkg::REG_FRAME_COLUMNS, 24'hFFF);
        write_register(drd_pkg::REG_FRAME_ROWS, 24'hFFF);
        send_row_value(32'sh7FFFFFFF);
        send_row_value(32'sh7FFFFFFF);
        send_row_value(32'sh80000000);
        send_row_value(32'sh80000000);
        send_row_value(32'sh7FFFFFFF);
        send_row_value(32'sh80000000);
        send_row_value(32'sh80000000);
        send_row_value(32'sh7FFFFFFF);
        send_row_value(32'sh7FFFFFFF);
        send_row_value(32'sh80000000);
        drain_detections();
        write_register(drd_pkg::REG_FRAME_COLUMNS, 24'd0);
        write_register(drd_pkg::REG_FRAME_ROWS, 24'd0);
        write_register(drd_pkg::REG_HSCALE, 24'h010000);
        write_register(drd_pkg::REG_VSCALE, 24'h010000);
        send_row_value(32'sh00100000);
        send_row_value(32'sh00100000);
        send_row_value(32'sh00080000);
        send_row_value(32'sh00080000);
        send_row_value(32'sh00010000);
        drain_detections();
    endtask

    // Single-stage rows: a tie between two classes, then a rejected row.
    task automatic test_single_stage();
        write_register(drd_pkg::REG_ANCHOR_FREE, 24'd0);
        write_register(drd_pkg::REG_CLASS_COUNT, 24'd2);
        write_register(drd_pkg::REG_SCORE_THRESHOLD, 24'h008000);
        write_register(drd_pkg::REG_FRAME_COLUMNS, 24'd640);
        write_register(drd_pkg::REG_FRAME_ROWS, 24'd480);
        send_row_value(32'sd100 << 16);
        send_row_value(32'sd100 << 16);
        send_row_value(32'sd50 << 16);
        send_row_value(32'sd40 << 16);
        send_row_value(32'sh00010000);
        send_row_value(32'sh00009000);
        send_row_value(32'sh00009000);
        send_row_value(32'sd100 << 16);
        send_row_value(32'sd100 << 16);
        send_row_value(32'sd50 << 16);
        send_row_value(32'sd40 << 16);
        send_row_value(32'sh00004000);
        send_row_value(32'sh7FFFFFFF);
        send_row_value(32'sh7FFFFFFF);
        drain_detections();
    endtask

    // Class count lowered mid-row: the next value ends the row.
    task automatic test_midrow_config();
        write_register(drd_pkg::REG_SCORE_THRESHOLD, 24'd0);
        write_register(drd_pkg::REG_ANCHOR_FREE, 24'd1);
        write_register(drd_pkg::REG_CLASS_COUNT, 24'd3);
        send_row_value(32'sd200 << 16);
        send_row_value(32'sd150 << 16);
        send_row_value(32'sd60 << 16);
        send_row_value(32'sd30 << 16);
        send_row_value(32'sh00008000);
        drain_detections();
        write_register(drd_pkg::REG_CLASS_COUNT, 24'd1);
        send_row_value(32'sh0000C000);
        drain_detections();
    endtask

    // Random phases: a fresh register setting each, then a run of row values
    // that need not end on a row boundary.
    task automatic test_random_phases();
        int phase;
        int n;
        int pick;
        logic [drd_pkg::CFG_DATA_W-1:0] data;
        phase = 0;
        while (random_items < RANDOM_ITEMS && phase < 120) begin
            drain_detections();
            pick = int'($urandom_range(0, 5));
            case (pick)
                0: data = '0;
                1: data = 24'h01FFFF;
                2: data = 24'h010000;
                3: data = drd_pkg::CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
                default: data = drd_pkg::CFG_DATA_W'($urandom_range(0, 17'h10000));
            endcase
            write_register(drd_pkg::REG_SCORE_THRESHOLD, data);
            write_register(drd_pkg::REG_ANCHOR_FREE,
                           drd_pkg::CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
            pick = int'($urandom_range(0, 19));
            n = int'($urandom_range(10, 60));
            if (pick == 0) begin
                data = '0;
            end else if (pick == 1 && big_rows < 2) begin
                data = drd_pkg::CFG_DATA_W'($urandom_range(drd_pkg::MAX_CLASSES_DEF, 255));
                n = 140;
                big_rows++;
            end else if (pick < 4) begin
                data = drd_pkg::CFG_DATA_W'($urandom_range(9, 20));
            end else begin
                data = drd_pkg::CFG_DATA_W'($urandom_range(1, 8));
            end
            write_register(drd_pkg::REG_CLASS_COUNT, data);
            pick = int'($urandom_range(0, 5));
            case (pick)
                0: data = '0;
                1: data = 24'hFFFFFF;
                2: data = 24'h010000;
                3: data = drd_pkg::CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
                default: data = drd_pkg::CFG_DATA_W'($urandom_range(0, 24'h030000));
            endcase
            write_register(drd_pkg::REG_HSCALE, data);
            write_register(drd_pkg::REG_VSCALE,
                           drd_pkg::CFG_DATA_W'((pick == 3) ? $urandom_range(0, 24'hFFFFFF)
                                                            : $urandom_range(0, 24'h030000)));
            pick = int'($urandom_range(0, 5));
            case (pick)
                0: data = '0;
                1: data = 24'hFFF;
                2: data = 24'd1;
                3: data = drd_pkg::CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
                default: data = drd_pkg::CFG_DATA_W'($urandom_range(1, 12'hFFF));
            endcase
            write_register(drd_pkg::REG_FRAME_COLUMNS, data);
            write_register(drd_pkg::REG_FRAME_ROWS,
                           drd_pkg::CFG_DATA_W'((pick == 3) ? $urandom_range(0, 24'hFFFFFF)
                                                            : $urandom_range(1, 12'hFFF)));
            if ($urandom_range(0, 7) == 0)
                write_register(REG_SPARE, drd_pkg::CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
            // Some phases run with no idling on either side.
            no_gaps = ($urandom_range(0, 3) == 0);
            no_backpressure = ($urandom_range(0, 3) == 0);
            repeat (n) begin
                send_row_value(draw_row_value());
                random_items++;
            end
            phase++;
        end
        no_gaps = 1'b0;
        no_backpressure = 1'b0;
        drain_detections();
    endtask

    // Main sequence: reset once, then each test in turn.
    initial begin
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_row_value <= '0;
        cfg_threshold = drd_pkg::RST_SCORE_THRESHOLD;
        cfg_anchor_free = drd_pkg::RST_ANCHOR_FREE;
        cfg_class_count = drd_pkg::RST_CLASS_COUNT;
        cfg_hscale = drd_pkg::RST_HSCALE;
        cfg_vscale = drd_pkg::RST_VSCALE;
        cfg_frame_columns = drd_pkg::RST_FRAME_COLUMNS;
        cfg_frame_rows = drd_pkg::RST_FRAME_ROWS;
        row_pos = 0;
        center_x = 0;
        center_y = 0;
        raw_width = 0;
        raw_height = 0;
        objectness = 0;
        best_score = 0;
        best_class = 0;
        row_rejected = 1'b0;
        mismatch_count = 0;
        random_items = 0;
        big_rows = 0;
        no_gaps = 1'b0;
        no_backpressure = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_config();
        test_extremes();
        test_single_stage();
        test_midrow_config();
        test_random_phases();

        if (mismatch_count == 0 && pending_detections.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Output side: before each detection beat, hold ready low for a random stall.
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_backpressure ? 0 : int'($urandom_range(0, 11));
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic note_mismatch(input string field, input longint expv, input longint actv);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%t: %s mismatch: expected %0d, got %0d", $realtime, field, expv, actv);
    endtask

    // Each detection beat is compared with the oldest predicted detection.
    always @(posedge i_clk) begin
        t_detection exp_det;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_detections.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%t: detection with none predicted: class %0d confidence %0d",
                             $realtime, o_class_index, o_confidence);
            end else begin
                exp_det = pending_detections.pop_front();
                if (exp_det.left !== o_box_left)
                    note_mismatch("box_left", exp_det.left, o_box_left);
                if (exp_det.top !== o_box_top)
                    note_mismatch("box_top", exp_det.top, o_box_top);
                if (exp_det.width !== o_box_width)
                    note_mismatch("box_width", exp_det.width, o_box_width);
                if (exp_det.height !== o_box_height)
                    note_mismatch("box_height", exp_det.height, o_box_height);
                if (exp_det.cls !== o_class_index)
                    note_mismatch("class_index", exp_det.cls, o_class_index);
                if (exp_det.conf !== o_confidence)
                    note_mismatch("confidence", exp_det.conf, o_confidence);
            end
        end
    end

    // Run limit.
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/drd_pkg.sv
design/drd_axis_clip.sv
design/detector_row_decode_core.sv
dv/tb.sv
